// ----- hw/rtl/ihex_pkg.sv -----
// Shared types, constants and a helper function for the Intel HEX record parser.
package ihex_pkg;

  // Character codes the parser reacts to.
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // Shortest legal line: colon, length, address, type and checksum pairs.
  localparam logic [9:0] MIN_LINE_CHARS = 10'd11;
  localparam logic [9:0] LINE_CHARS_MAX = 10'd1023;

  // Record type codes.
  localparam logic [7:0] REC_DATA = 8'd0;
  localparam logic [7:0] REC_EOF  = 8'd1;

  // Result kinds.
  localparam logic RES_DATA = 1'b0;
  localparam logic RES_END  = 1'b1;

  // Parse status codes reported in the record end result.
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NO_COLON  = 4'd1;
  localparam logic [3:0] ST_SHORT     = 4'd2;
  localparam logic [3:0] ST_TRUNC     = 4'd3;
  localparam logic [3:0] ST_BAD_LEN   = 4'd4;
  localparam logic [3:0] ST_BAD_ADDR  = 4'd5;
  localparam logic [3:0] ST_BAD_TYPE  = 4'd6;
  localparam logic [3:0] ST_BAD_DATA  = 4'd7;
  localparam logic [3:0] ST_BAD_CKFLD = 4'd8;
  localparam logic [3:0] ST_BAD_CKSUM = 4'd9;

  // One input beat.
  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic        result_kind;
    logic [15:0] byte_address;
    logic [7:0]  data_byte;
    logic [7:0]  record_type;
    logic [7:0]  record_length;
    logic [3:0]  parse_status;
    logic        file_ended;
  } result_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/ihex_in_if.sv -----
// Valid/ready channel that carries text characters into the parser.
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

// ----- hw/rtl/ihex_out_if.sv -----
// Valid/ready channel that carries parser results out.
interface ihex_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] byte_address;
  logic [7:0]  data_byte;
  logic [7:0]  record_type;
  logic [7:0]  record_length;
  logic [3:0]  parse_status;
  logic        file_ended;

  modport source (output valid, output result_kind, output byte_address, output data_byte,
                  output record_type, output record_length, output parse_status,
                  output file_ended, input ready);
  modport sink   (input valid, input result_kind, input byte_address, input data_byte,
                  input record_type, input record_length, input parse_status,
                  input file_ended, output ready);
endinterface

// ----- hw/rtl/ihex_in_reg.sv -----
// Input register stage that captures one character beat per cycle while the engine takes beats.
module ihex_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ihex_pkg::in_beat_t in_beat,
  output logic              beat_valid,
  input  logic              beat_take,
  output ihex_pkg::in_beat_t beat
);

  logic               valid_r;
  ihex_pkg::in_beat_t beat_r;

  // A new beat may enter when the register is empty or drains this cycle.
  assign in_ready   = !valid_r || beat_take;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  // Valid flag and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (beat_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

endmodule

// ----- hw/rtl/ihex_engine.sv -----
// Line parsing state and the per-character update logic.
module ihex_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat_valid,
  output logic               beat_take,
  input  ihex_pkg::in_beat_t beat,
  input  logic               res_ready,
  output logic               res_valid,
  output ihex_pkg::result_t  res
);

  logic [9:0]  line_chars_r, line_chars_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic [7:0]  declared_length_r, declared_length_nxt;
  logic [15:0] record_addr_r, record_addr_nxt;
  logic [7:0]  type_field_r, type_field_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [7:0]  bytes_seen_r, bytes_seen_nxt;
  logic [3:0]  first_error_r, first_error_nxt;
  logic        colon_seen_r, colon_seen_nxt;
  logic        file_done_r, file_done_nxt;

  logic        fire;
  logic        line_end;
  logic [8:0]  q;
  logic [8:0]  data_end;
  logic        past_end;
  logic [3:0]  pair_code;
  logic [4:0]  hex;
  logic [7:0]  byte_val;
  logic [10:0] need;
  logic [3:0]  status;
  logic        ends;

  // A beat is consumed whenever the result side can take a result.
  assign fire      = beat_valid && res_ready;
  assign beat_take = fire;
  assign line_end  = beat.end_of_text || (beat.text_char == ihex_pkg::CHAR_NL);

  // Pair index within the line and the field that pair belongs to.
  assign q        = 9'((line_chars_r - 10'd1) >> 1);
  assign data_end = {1'b0, declared_length_r} + 9'd4;
  assign past_end = (q != 9'd0) && (q > data_end);
  assign hex      = ihex_pkg::hex_decode(beat.text_char);
  assign byte_val = {high_nibble_r, hex[3:0]};

  always_comb begin
    if (q == 9'd0) begin
      pair_code = ihex_pkg::ST_BAD_LEN;
    end else if (q <= 9'd2) begin
      pair_code = ihex_pkg::ST_BAD_ADDR;
    end else if (q == 9'd3) begin
      pair_code = ihex_pkg::ST_BAD_TYPE;
    end else if (q < data_end) begin
      pair_code = ihex_pkg::ST_BAD_DATA;
    end else begin
      pair_code = ihex_pkg::ST_BAD_CKFLD;
    end
  end

  // Status of the line as it stands, in priority order.
  assign need = 11'd11 + {2'b00, declared_length_r, 1'b0};
  always_comb begin
    if (!colon_seen_r) begin
      status = ihex_pkg::ST_NO_COLON;
    end else if (line_chars_r < ihex_pkg::MIN_LINE_CHARS) begin
      status = ihex_pkg::ST_SHORT;
    end else if (first_error_r == ihex_pkg::ST_BAD_LEN) begin
      status = ihex_pkg::ST_BAD_LEN;
    end else if ({1'b0, line_chars_r} < need) begin
      status = ihex_pkg::ST_TRUNC;
    end else if (first_error_r != ihex_pkg::ST_OK) begin
      status = first_error_r;
    end else if (running_sum_r != 8'd0) begin
      status = ihex_pkg::ST_BAD_CKSUM;
    end else begin
      status = ihex_pkg::ST_OK;
    end
  end

  assign ends = (type_field_r == ihex_pkg::REC_EOF) &&
                (status == ihex_pkg::ST_OK || status == ihex_pkg::ST_BAD_DATA ||
                 status == ihex_pkg::ST_BAD_CKFLD || status == ihex_pkg::ST_BAD_CKSUM);

  // Next state and the result of this beat.
  always_comb begin
    line_chars_nxt      = line_chars_r;
    high_nibble_nxt     = high_nibble_r;
    declared_length_nxt = declared_length_r;
    record_addr_nxt     = record_addr_r;
    type_field_nxt      = type_field_r;
    running_sum_nxt     = running_sum_r;
    bytes_seen_nxt      = bytes_seen_r;
    first_error_nxt     = first_error_r;
    colon_seen_nxt      = colon_seen_r;
    file_done_nxt       = file_done_r;
    res_valid           = 1'b0;
    res                 = '0;

    if (fire && !file_done_r) begin
      if (line_end) begin
        if (line_chars_r != 10'd0) begin
          res_valid         = 1'b1;
          res.result_kind   = ihex_pkg::RES_END;
          res.byte_address  = record_addr_r;
          res.record_type   = type_field_r;
          res.record_length = declared_length_r;
          res.parse_status  = status;
          res.file_ended    = ends;
          file_done_nxt       = ends;
          line_chars_nxt      = 10'd0;
          high_nibble_nxt     = 4'd0;
          declared_length_nxt = 8'd0;
          record_addr_nxt     = 16'd0;
          type_field_nxt      = 8'd0;
          running_sum_nxt     = 8'd0;
          bytes_seen_nxt      = 8'd0;
          first_error_nxt     = ihex_pkg::ST_OK;
          colon_seen_nxt      = 1'b0;
        end
      end else begin
        if (line_chars_r != ihex_pkg::LINE_CHARS_MAX) begin
          line_chars_nxt = line_chars_r + 10'd1;
        end
        if (line_chars_r == 10'd0) begin
          colon_seen_nxt = (beat.text_char == ihex_pkg::CHAR_COLON);
        end else if (colon_seen_r && first_error_r == ihex_pkg::ST_OK && !past_end) begin
          if (!hex[4]) begin
            first_error_nxt = pair_code;
          end else if (line_chars_r[0]) begin
            // Odd position: first digit of a pair.
            high_nibble_nxt = hex[3:0];
          end else begin
            // Even position: the pair is complete.
            running_sum_nxt = running_sum_r + byte_val;
            if (q == 9'd0) begin
              declared_length_nxt = byte_val;
            end else if (q == 9'd1) begin
              record_addr_nxt = {byte_val, 8'd0};
            end else if (q == 9'd2) begin
              record_addr_nxt = {record_addr_r[15:8], byte_val};
            end else if (q == 9'd3) begin
              type_field_nxt = byte_val;
            end else if (pair_code == ihex_pkg::ST_BAD_DATA) begin
              bytes_seen_nxt = bytes_seen_r + 8'd1;
              if (type_field_r == ihex_pkg::REC_DATA) begin
                res_valid         = 1'b1;
                res.result_kind   = ihex_pkg::RES_DATA;
                res.byte_address  = record_addr_r + {8'd0, bytes_seen_r};
                res.data_byte     = byte_val;
                res.record_length = declared_length_r;
              end
            end
          end
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_chars_r      <= 10'd0;
      high_nibble_r     <= 4'd0;
      declared_length_r <= 8'd0;
      record_addr_r     <= 16'd0;
      type_field_r      <= 8'd0;
      running_sum_r     <= 8'd0;
      bytes_seen_r      <= 8'd0;
      first_error_r     <= ihex_pkg::ST_OK;
      colon_seen_r      <= 1'b0;
      file_done_r       <= 1'b0;
    end else begin
      line_chars_r      <= line_chars_nxt;
      high_nibble_r     <= high_nibble_nxt;
      declared_length_r <= declared_length_nxt;
      record_addr_r     <= record_addr_nxt;
      type_field_r      <= type_field_nxt;
      running_sum_r     <= running_sum_nxt;
      bytes_seen_r      <= bytes_seen_nxt;
      first_error_r     <= first_error_nxt;
      colon_seen_r      <= colon_seen_nxt;
      file_done_r       <= file_done_nxt;
    end
  end

`ifndef SYNTHESIS
  // Once the file has ended the parser stays ended until reset.
  a_file_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    file_done_r |=> file_done_r)
    else $error("file end flag dropped without reset");

  // An empty line holds no colon and no error.
  a_empty_line_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (line_chars_r == 10'd0) |-> (!colon_seen_r && first_error_r == ihex_pkg::ST_OK))
    else $error("empty line carries parse state");

  // Data bytes are only given while the line is clean.
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.result_kind == ihex_pkg::RES_DATA) |->
      (first_error_r == ihex_pkg::ST_OK && colon_seen_r && !res.file_ended))
    else $error("data byte given from a faulty line");
`endif

endmodule

// ----- hw/rtl/ihex_out_reg.sv -----
// Output register stage that holds one result beat until it is taken.
module ihex_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  ihex_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output ihex_pkg::result_t out_res
);

  logic              valid_r;
  ihex_pkg::result_t res_r;

  // The stage can load when empty or when its beat leaves this cycle.
  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

endmodule

// ----- hw/rtl/intel_hex_record_parser_unit.sv -----
// Intel HEX record parser: takes text characters, gives data bytes and record summaries.
// A character is held in the input register; its result, if any, is registered in the output register.
// Throughput: one character per cycle while the result register can load.
// The input register can take one new character while a result waits in the output register.
// Reset (rst_n low, synchronous) clears the line state, the end-of-file flag
// and both stage valid flags.
module intel_hex_record_parser_unit (
  input  logic clk,
  input  logic rst_n,
  ihex_in_if.sink    in_bus,
  ihex_out_if.source out_bus
);

  ihex_pkg::in_beat_t in_beat;
  ihex_pkg::in_beat_t beat;
  logic               beat_valid;
  logic               beat_take;
  logic               res_valid;
  logic               res_ready;
  ihex_pkg::result_t  res;
  ihex_pkg::result_t  out_res;

  assign in_beat.text_char   = in_bus.text_char;
  assign in_beat.end_of_text = in_bus.end_of_text;

  // Input register.
  ihex_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_beat    (in_beat),
    .beat_valid (beat_valid),
    .beat_take  (beat_take),
    .beat       (beat)
  );

  // Parsing state and update logic.
  ihex_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat_take  (beat_take),
    .beat       (beat),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register.
  ihex_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_res   (out_res)
  );

  assign out_bus.result_kind   = out_res.result_kind;
  assign out_bus.byte_address  = out_res.byte_address;
  assign out_bus.data_byte     = out_res.data_byte;
  assign out_bus.record_type   = out_res.record_type;
  assign out_bus.record_length = out_res.record_length;
  assign out_bus.parse_status  = out_res.parse_status;
  assign out_bus.file_ended    = out_res.file_ended;

endmodule

// ----- tb/sv/intel_hex_record_parser_unit_tb.sv -----
// Self-checking testbench for the Intel HEX record parser: directed lines, then random records.
`timescale 1ns / 100ps

module intel_hex_record_parser_unit_tb;

  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CHARS = 180;
  localparam int QUIET_CHARS = 70;
  localparam int DRAIN_CYCLES = 20;
  localparam int GAP_PCT = 26;
  localparam int SINK_HOLD = 150;
  localparam int PRESSURE_LEN = 40;

  // Per-line parser state plus the sticky end-of-file flag.
  typedef struct packed {
    logic [9:0]  n_chars;
    logic [3:0]  hi_nib;
    logic [7:0]  len;
    logic [15:0] addr;
    logic [7:0]  rtype;
    logic [7:0]  sum;
    logic [7:0]  nbytes;
    logic [3:0]  err;
    logic        colon;
    logic        done;
  } line_state_t;

  // One directed line: its text, optional filler, how it closes and a fixed end result.
  typedef struct {
    string             text;
    int                pad;
    logic [7:0]        pad_char;
    bit                by_eot;
    bit                typed;
    ihex_pkg::result_t want;
  } text_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ihex_in_if  in_bus();
  ihex_out_if out_bus();

  line_state_t       parser_state;
  ihex_pkg::result_t pending_results[$];
  logic [7:0]        line_buf[$];
  text_row_t         dir_rows[$];
  int                fail_count = 0;
  int                cycle_count = 0;
  int                src_gap_pct = GAP_PCT;
  int                snk_stall_pct = GAP_PCT;
  int                hold_cycles = 0;

  intel_hex_record_parser_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always #4 clk = ~clk;

  // Decode one hex digit of either case; returns 0 for any other character.
  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = c[3:0];
    end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      v = c[3:0] + 4'd9;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return (lower ? 8'("a") : 8'("A")) + 8'(n - 4'd10);
  endfunction

  // Status of a closing line, in priority order.
  function automatic logic [3:0] end_status(input line_state_t s);
    int need;
    need = 11 + 2 * int'(s.len);
    if (!s.colon) return ihex_pkg::ST_NO_COLON;
    if (s.n_chars < ihex_pkg::MIN_LINE_CHARS) return ihex_pkg::ST_SHORT;
    if (s.err == ihex_pkg::ST_BAD_LEN) return ihex_pkg::ST_BAD_LEN;
    if (int'(s.n_chars) < need) return ihex_pkg::ST_TRUNC;
    if (s.err != ihex_pkg::ST_OK) return s.err;
    if (s.sum != 8'd0) return ihex_pkg::ST_BAD_CKSUM;
    return ihex_pkg::ST_OK;
  endfunction

  // Advance the parser by one beat; returns 1 when the beat yields a result.
  function automatic bit parse_char(inout line_state_t s, input logic [7:0] c,
                                    input logic eot, output ihex_pkg::result_t r);
    int unsigned pos;
    int unsigned pair;
    int unsigned dlen;
    logic [3:0]  code;
    logic [3:0]  nib;
    logic [7:0]  b;
    logic [3:0]  st;
    logic        ends;
    r = '0;
    if (s.done) return 1'b0;

    // Newline or end of text closes a non-empty line.
    if (eot || c == ihex_pkg::CHAR_NL) begin
      if (s.n_chars == 10'd0) return 1'b0;
      st = end_status(s);
      ends = (s.rtype == ihex_pkg::REC_EOF) &&
             (st == ihex_pkg::ST_OK || st == ihex_pkg::ST_BAD_DATA ||
              st == ihex_pkg::ST_BAD_CKFLD || st == ihex_pkg::ST_BAD_CKSUM);
      r.result_kind = ihex_pkg::RES_END;
      r.byte_address = s.addr;
      r.record_type = s.rtype;
      r.record_length = s.len;
      r.parse_status = st;
      r.file_ended = ends;
      s = '0;
      s.done = ends;
      return 1'b1;
    end

    pos = s.n_chars;
    if (s.n_chars != ihex_pkg::LINE_CHARS_MAX) s.n_chars = s.n_chars + 10'd1;
    if (pos == 0) begin
      s.colon = (c == ihex_pkg::CHAR_COLON);
      return 1'b0;
    end
    if (!s.colon || s.err != ihex_pkg::ST_OK) return 1'b0;

    // Which pair this character belongs to decides the error it would raise.
    pair = (pos - 1) / 2;
    dlen = s.len;
    if (pair > 4 + dlen) return 1'b0;
    if (pair == 0) code = ihex_pkg::ST_BAD_LEN;
    else if (pair <= 2) code = ihex_pkg::ST_BAD_ADDR;
    else if (pair == 3) code = ihex_pkg::ST_BAD_TYPE;
    else if (pair < 4 + dlen) code = ihex_pkg::ST_BAD_DATA;
    else code = ihex_pkg::ST_BAD_CKFLD;

    if (!hex_nibble(c, nib)) begin
      s.err = code;
      return 1'b0;
    end
    if (pos % 2 == 1) begin
      s.hi_nib = nib;
      return 1'b0;
    end

    b = {s.hi_nib, nib};
    s.sum = s.sum + b;
    case (pair)
      0: s.len = b;
      1: s.addr = {b, 8'h00};
      2: s.addr = s.addr | {8'h00, b};
      3: s.rtype = b;
      default: begin
        if (code == ihex_pkg::ST_BAD_DATA) begin
          r.byte_address = s.addr + 16'(s.nbytes);
          s.nbytes = s.nbytes + 8'd1;
          if (s.rtype == ihex_pkg::REC_DATA) begin
            r.result_kind = ihex_pkg::RES_DATA;
            r.data_byte = b;
            r.record_length = s.len;
            return 1'b1;
          end
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic ihex_pkg::result_t end_of(input logic [15:0] a, input logic [7:0] rtype,
                                               input logic [7:0] len, input logic [3:0] st,
                                               input logic ends);
    return '{ihex_pkg::RES_END, a, 8'h00, rtype, len, st, ends};
  endfunction

  function automatic void add_row(input string text, input bit by_eot, input bit typed,
                                  input ihex_pkg::result_t want, input int pad = 0,
                                  input logic [7:0] pad_char = 8'h00);
    dir_rows.push_back('{text, pad, pad_char, by_eot, typed, want});
  endfunction

  function automatic void load_text(input string text);
    line_buf = {};
    for (int k = 0; k < text.len(); k++) line_buf.push_back(8'(text[k]));
  endfunction

  // Encode a record with a correct or a deliberately wrong checksum into the line buffer.
  function automatic void build_record(input int dlen, input logic [15:0] a,
                                       input logic [7:0] rtype, input bit good_sum);
    logic [7:0] rec_bytes[$];
    logic [7:0] sum;
    rec_bytes = {8'(dlen), a[15:8], a[7:0], rtype};
    repeat (dlen) rec_bytes.push_back(8'($urandom_range(255)));
    sum = 8'd0;
    foreach (rec_bytes[i]) sum = sum + rec_bytes[i];
    sum = 8'd0 - sum;
    if (!good_sum) sum = sum + 8'($urandom_range(1, 255));
    rec_bytes.push_back(sum);
    line_buf = {ihex_pkg::CHAR_COLON};
    foreach (rec_bytes[i]) begin
      line_buf.push_back(hex_char(rec_bytes[i][7:4], 1'($urandom_range(1))));
      line_buf.push_back(hex_char(rec_bytes[i][3:0], 1'($urandom_range(1))));
    end
  endfunction

  // Offer one beat, wait for it to be taken, then predict what it causes.
  task automatic send_beat(input logic [7:0] c, input logic eot, input bit typed,
                           input ihex_pkg::result_t want);
    ihex_pkg::result_t got;
    bit                emit;
    while ($urandom_range(99) < src_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.text_char <= c;
    in_bus.end_of_text <= eot;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    emit = parse_char(parser_state, c, eot, got);
    if (typed) pending_results.push_back(want);
    else if (emit) pending_results.push_back(got);
  endtask

  // Send the line buffer and close it with a newline or an end-of-text beat.
  task automatic send_line(input bit by_eot, input bit typed, input ihex_pkg::result_t want);
    foreach (line_buf[i]) send_beat(line_buf[i], 1'b0, 1'b0, '0);
    send_beat(by_eot ? 8'($urandom_range(255)) : ihex_pkg::CHAR_NL, by_eot, typed, want);
  endtask

  function automatic void cmp_field(input string name, input logic [15:0] exp_v,
                                    input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Compare every result beat with the oldest expectation.
  always @(posedge clk) begin : watch_results
    ihex_pkg::result_t got;
    ihex_pkg::result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.result_kind, out_bus.byte_address, out_bus.data_byte,
              out_bus.record_type, out_bus.record_length, out_bus.parse_status,
              out_bus.file_ended};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
        cmp_field("byte_address", want.byte_address, got.byte_address);
        cmp_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
        cmp_field("record_type", 16'(want.record_type), 16'(got.record_type));
        cmp_field("record_length", 16'(want.record_length), 16'(got.record_length));
        cmp_field("parse_status", 16'(want.parse_status), 16'(got.parse_status));
        cmp_field("file_ended", 16'(want.file_ended), 16'(got.file_ended));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL intel_hex_record_parser_unit");
      $finish;
    end
  end

  initial begin : stimulus
    line_state_t       trial;
    ihex_pkg::result_t scratch;
    int                pick;
    int                dlen;
    int                rand_chars;
    bit                by_eot;
    logic [7:0]        rtype;

    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.text_char <= 8'h00;
    in_bus.end_of_text <= 1'b0;
    parser_state = '0;

    // Directed lines: empty lines, every status code, edge addresses and characters.
    add_row("", 1'b0, 1'b0, '0);
    add_row("", 1'b1, 1'b0, '0);
    add_row("A", 1'b0, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_NO_COLON, 1'b0));
    add_row("", 1'b0, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_NO_COLON, 1'b0),
            1, 8'h00);
    add_row("\r", 1'b0, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_NO_COLON, 1'b0));
    add_row(":", 1'b0, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_SHORT, 1'b0));
    add_row(":10000000", 1'b1, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h10, ihex_pkg::ST_SHORT, 1'b0));
    add_row(":G0000000000", 1'b0, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_BAD_LEN, 1'b0));
    add_row(":0212340011", 1'b0, 1'b1,
            end_of(16'h1234, ihex_pkg::REC_DATA, 8'h02, ihex_pkg::ST_TRUNC, 1'b0));
    add_row(":00X1000000", 1'b0, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_BAD_ADDR, 1'b0));
    add_row(":001234Z000", 1'b0, 1'b1,
            end_of(16'h1234, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_BAD_TYPE, 1'b0));
    add_row(":020000001G2200", 1'b0, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h02, ihex_pkg::ST_BAD_DATA, 1'b0));
    add_row(":00000000GG", 1'b0, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_BAD_CKFLD, 1'b0));
    add_row(":0000000000", 1'b0, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_OK, 1'b0));
    add_row(":00000000FF", 1'b1, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_BAD_CKSUM, 1'b0));
    // A truncated end-of-file record does not end the file.
    add_row(":0100000100", 1'b0, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_EOF, 8'h01, ihex_pkg::ST_TRUNC, 1'b0));
    add_row(":10010000214601360121470136007EFE09D2190140", 1'b0, 1'b0, '0);
    add_row(":0300300002337a1e", 1'b0, 1'b0, '0);
    add_row(":02FFFF00AABB9B", 1'b0, 1'b0, '0);
    add_row(":020000040800F2", 1'b0, 1'b0, '0);
    // Text after the checksum pair is ignored.
    add_row(":0000000000", 1'b0, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_OK, 1'b0),
            30, 8'("x"));
    add_row(":0000000000", 1'b0, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_OK, 1'b0),
            3, 8'hFF);
    add_row(":0000000000\r", 1'b1, 1'b1,
            end_of(16'h0000, ihex_pkg::REC_DATA, 8'h00, ihex_pkg::ST_OK, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      load_text(dir_rows[r].text);
      repeat (dir_rows[r].pad) line_buf.push_back(dir_rows[r].pad_char);
      send_line(dir_rows[r].by_eot, dir_rows[r].typed, dir_rows[r].want);
    end

    // A long data record while the result side holds off, so the input backs up.
    src_gap_pct = 0;
    snk_stall_pct = 0;
    hold_cycles = SINK_HOLD;
    build_record(PRESSURE_LEN, 16'($urandom_range(65535)), ihex_pkg::REC_DATA, 1'b1);
    send_line(1'b0, 1'b0, '0);

    // Random lines: mostly good records, the rest damaged or noise.
    rand_chars = 0;
    while (rand_chars < RANDOM_CHARS) begin
      if (rand_chars >= QUIET_CHARS) begin
        src_gap_pct = GAP_PCT;
        snk_stall_pct = GAP_PCT;
      end
      do begin
        pick = $urandom_range(99);
        dlen = $urandom_range(99);
        dlen = (dlen < 60) ? $urandom_range(4) :
               (dlen < 95) ? $urandom_range(5, 16) : $urandom_range(17, 40);
        rtype = ($urandom_range(4) == 0) ? 8'($urandom_range(2, 255)) : ihex_pkg::REC_DATA;
        build_record(dlen, 16'($urandom_range(65535)), rtype, pick >= 10);
        if (pick < 55) begin
          // Well-formed record, sometimes with a wrong checksum.
        end else if (pick < 65) begin
          repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(11, 255)));
        end else if (pick < 75) begin
          line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
        end else if (pick < 83) begin
          dlen = $urandom_range(line_buf.size() - 1);
          while (line_buf.size() > dlen) void'(line_buf.pop_back());
        end else if (pick < 88) begin
          line_buf[0] = 8'($urandom_range(11, 57));
        end else begin
          line_buf = {};
          if ($urandom_range(1) == 1) line_buf.push_back(ihex_pkg::CHAR_COLON);
          repeat ($urandom_range(14)) line_buf.push_back(8'($urandom_range(255)));
        end
        by_eot = ($urandom_range(9) == 0);
        // Keep the file open: reject any line that would end it.
        trial = parser_state;
        foreach (line_buf[i]) void'(parse_char(trial, line_buf[i], 1'b0, scratch));
        void'(parse_char(trial, ihex_pkg::CHAR_NL, by_eot, scratch));
      end while (trial.done);
      send_line(by_eot, 1'b0, '0);
      rand_chars += line_buf.size() + 1;
    end

    // End-of-file record in one of its closing forms, then text that must be ignored.
    case ($urandom_range(3))
      0: load_text(":00000001FF");
      1: load_text(":00000001FE");
      2: load_text(":00000001GG");
      default: load_text(":01000001ZZFE");
    endcase
    send_line(1'($urandom_range(1)), 1'b0, '0);
    load_text(":0300300002337A1E");
    send_line(1'b0, 1'b0, '0);
    load_text("x");
    send_line(1'b1, 1'b0, '0);
    in_bus.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS intel_hex_record_parser_unit");
    end else begin
      $display("FAIL intel_hex_record_parser_unit");
    end
    $finish;
  end

endmodule

// ----- intel_hex_record_parser_unit.f -----
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_in_if.sv
hw/rtl/ihex_out_if.sv
hw/rtl/ihex_in_reg.sv
hw/rtl/ihex_engine.sv
hw/rtl/ihex_out_reg.sv
hw/rtl/intel_hex_record_parser_unit.sv
tb/sv/intel_hex_record_parser_unit_tb.sv
